>>> sv/vhs_pkg.sv
// shared types, register map and constants of the vad hangover smoother
package vhs_pkg;

    localparam int MaxLookbackDef = 32;
    localparam int CountBitsDef   = 10;

    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 16;
    localparam int ScoreW    = 16;
    localparam int ThrW      = 10;
    localparam int LookbackW = 6;

    localparam logic [CfgIdxW-1:0] REG_SCORE_THR = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ONSET     = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_RELEASE   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_ENDPOINT  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_LOOKBACK  = 3'd4;

    localparam logic [ScoreW-1:0]    SCORE_THR_RST = 16'd32768;
    localparam logic [ThrW-1:0]      ONSET_RST     = 10'd3;
    localparam logic [ThrW-1:0]      RELEASE_RST   = 10'd15;
    localparam logic [ThrW-1:0]      ENDPOINT_RST  = 10'd50;
    localparam logic [LookbackW-1:0] LOOKBACK_RST  = 6'd0;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_FLUSH = 1'b1
    } t_vhs_op;

    typedef enum logic {
        ST_SILENCE = 1'b0,
        ST_SPEECH  = 1'b1
    } t_vhs_state;

    typedef struct packed {
        logic [ScoreW-1:0]    score_thr;
        logic [ThrW-1:0]      onset;
        logic [ThrW-1:0]      release_len;
        logic [ThrW-1:0]      endpoint;
        logic [LookbackW-1:0] lookback;
    } t_vhs_cfg;

    // bit 0 speech_out, bit 1 smoothed, bit 2 endpoint
    typedef struct packed {
        logic endpoint;
        logic smoothed;
        logic speech;
    } t_vhs_flags;

    typedef struct packed {
        logic       last;
        t_vhs_flags flags;
    } t_vhs_result;

endpackage

>>> sv/vhs_cfg.sv
// configuration register file of the vad hangover smoother
module vhs_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [vhs_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [vhs_pkg::CfgDataW-1:0] i_cfg_data,
    output vhs_pkg::t_vhs_cfg            o_cfg
);

    vhs_pkg::t_vhs_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.score_thr   <= vhs_pkg::SCORE_THR_RST;
            r_cfg.onset       <= vhs_pkg::ONSET_RST;
            r_cfg.release_len <= vhs_pkg::RELEASE_RST;
            r_cfg.endpoint    <= vhs_pkg::ENDPOINT_RST;
            r_cfg.lookback    <= vhs_pkg::LOOKBACK_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                vhs_pkg::REG_SCORE_THR: r_cfg.score_thr   <= i_cfg_data;
                vhs_pkg::REG_ONSET:     r_cfg.onset       <= i_cfg_data[vhs_pkg::ThrW-1:0];
                vhs_pkg::REG_RELEASE:   r_cfg.release_len <= i_cfg_data[vhs_pkg::ThrW-1:0];
                vhs_pkg::REG_ENDPOINT:  r_cfg.endpoint    <= i_cfg_data[vhs_pkg::ThrW-1:0];
                vhs_pkg::REG_LOOKBACK:  r_cfg.lookback    <= i_cfg_data[vhs_pkg::LookbackW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/vhs_hangover.sv
// silence/speech hangover state machine with saturating run counters
module vhs_hangover #(
    parameter int COUNT_BITS = vhs_pkg::CountBitsDef
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_clear,
    input  logic [vhs_pkg::ScoreW-1:0] i_score,
    input  vhs_pkg::t_vhs_cfg          i_cfg,
    output vhs_pkg::t_vhs_flags        o_flags
);

    localparam int CmpW = (COUNT_BITS > vhs_pkg::ThrW) ? COUNT_BITS : vhs_pkg::ThrW;

    vhs_pkg::t_vhs_state   r_state;
    vhs_pkg::t_vhs_state   n_state;
    logic [COUNT_BITS-1:0] r_voice_run;
    logic [COUNT_BITS-1:0] n_voice_run;
    logic [COUNT_BITS-1:0] r_silent_run;
    logic [COUNT_BITS-1:0] n_silent_run;
    logic [COUNT_BITS-1:0] voice_inc;
    logic [COUNT_BITS-1:0] silent_inc;
    logic                  voice;

    assign voice      = (i_score <= i_cfg.score_thr);
    assign voice_inc  = (r_voice_run == '1) ? r_voice_run : r_voice_run + 1'b1;
    assign silent_inc = (r_silent_run == '1) ? r_silent_run : r_silent_run + 1'b1;

    // next state
    always_comb begin
        n_state      = r_state;
        n_voice_run  = r_voice_run;
        n_silent_run = r_silent_run;
        unique case (r_state)
            vhs_pkg::ST_SILENCE: begin
                if (voice) begin
                    n_voice_run = voice_inc;
                    if (CmpW'(voice_inc) >= CmpW'(i_cfg.onset)) begin
                        n_state      = vhs_pkg::ST_SPEECH;
                        n_silent_run = '0;
                    end
                end else begin
                    n_voice_run  = '0;
                    n_silent_run = silent_inc;
                end
            end
            vhs_pkg::ST_SPEECH: begin
                if (!voice) begin
                    n_silent_run = silent_inc;
                    if (CmpW'(silent_inc) >= CmpW'(i_cfg.release_len)) begin
                        n_state     = vhs_pkg::ST_SILENCE;
                        n_voice_run = '0;
                    end
                end else begin
                    n_silent_run = '0;
                    n_voice_run  = voice_inc;
                end
            end
            default: n_state = vhs_pkg::ST_SILENCE;
        endcase
    end

    // frame decision
    always_comb begin
        o_flags.speech   = (n_state == vhs_pkg::ST_SPEECH);
        o_flags.smoothed = (n_state == vhs_pkg::ST_SPEECH);
        o_flags.endpoint = (r_state == vhs_pkg::ST_SILENCE) && !voice
                           && (CmpW'(silent_inc) >= CmpW'(i_cfg.endpoint));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state      <= vhs_pkg::ST_SILENCE;
            r_voice_run  <= '0;
            r_silent_run <= '0;
        end else if (i_step) begin
            r_state      <= n_state;
            r_voice_run  <= n_voice_run;
            r_silent_run <= n_silent_run;
        end
    end

endmodule

>>> sv/vhs_lookback.sv
// lookback delay line: marks waiting frames at speech, emits and flushes them
module vhs_lookback #(
    parameter int MAX_LOOKBACK = vhs_pkg::MaxLookbackDef
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  vhs_pkg::t_vhs_op                  i_op,
    input  vhs_pkg::t_vhs_flags               i_flags,
    input  logic [vhs_pkg::LookbackW-1:0]     i_lookback,
    output logic                              o_emit_valid,
    output vhs_pkg::t_vhs_result              o_emit,
    output logic                              o_done,
    output logic                              o_clear,
    output logic [$clog2(MAX_LOOKBACK+1)-1:0] o_count
);

    localparam int CntW = $clog2(MAX_LOOKBACK + 1);
    localparam int LbW  = (CntW > vhs_pkg::LookbackW) ? CntW : vhs_pkg::LookbackW;

    vhs_pkg::t_vhs_flags r_pend [MAX_LOOKBACK];
    vhs_pkg::t_vhs_flags n_pend [MAX_LOOKBACK];
    vhs_pkg::t_vhs_flags ored   [MAX_LOOKBACK+1];
    logic [CntW-1:0]     r_count;
    logic [CntW-1:0]     n_count;
    logic [LbW-1:0]      lb;

    assign lb = (LbW'(i_lookback) > LbW'(MAX_LOOKBACK)) ? LbW'(MAX_LOOKBACK)
                                                         : LbW'(i_lookback);

    // waiting frames marked by a speech frame
    always_comb begin
        for (int i = 0; i < MAX_LOOKBACK; i++) begin
            ored[i]        = r_pend[i];
            ored[i].speech = r_pend[i].speech
                             | (i_flags.speech & (CntW'(i) < r_count));
        end
        ored[MAX_LOOKBACK] = '0;
    end

    always_comb begin
        n_pend       = r_pend;
        n_count      = r_count;
        o_emit_valid = 1'b0;
        o_emit       = '0;
        o_done       = 1'b0;
        o_clear      = 1'b0;
        if (i_fire) begin
            unique case (i_op)
                vhs_pkg::OP_FRAME: begin
                    o_done = 1'b1;
                    if (LbW'(r_count) < lb) begin
                        for (int i = 0; i < MAX_LOOKBACK; i++) begin
                            n_pend[i] = (CntW'(i) == r_count) ? i_flags : ored[i];
                        end
                        n_count = r_count + 1'b1;
                    end else if (r_count == '0) begin
                        o_emit_valid = 1'b1;
                        o_emit.last  = 1'b1;
                        o_emit.flags = i_flags;
                    end else begin
                        o_emit_valid = 1'b1;
                        o_emit.last  = 1'b1;
                        o_emit.flags = ored[0];
                        for (int i = 0; i < MAX_LOOKBACK; i++) begin
                            if (CntW'(i) + 1'b1 < r_count) begin
                                n_pend[i] = ored[i+1];
                            end else if (CntW'(i) + 1'b1 == r_count) begin
                                n_pend[i] = i_flags;
                            end else begin
                                n_pend[i] = ored[i];
                            end
                        end
                    end
                end
                vhs_pkg::OP_FLUSH: begin
                    if (r_count == '0) begin
                        o_done  = 1'b1;
                        o_clear = 1'b1;
                    end else begin
                        o_emit_valid = 1'b1;
                        o_emit.flags = r_pend[0];
                        o_emit.last  = (r_count == CntW'(1));
                        for (int i = 0; i < MAX_LOOKBACK; i++) begin
                            n_pend[i] = r_pend[i];
                            if (i < MAX_LOOKBACK - 1) begin
                                n_pend[i] = ored[i+1];
                                n_pend[i].speech = r_pend[(i+1) % MAX_LOOKBACK].speech;
                            end
                        end
                        n_count = r_count - 1'b1;
                        if (r_count == CntW'(1)) begin
                            o_done  = 1'b1;
                            o_clear = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    assign o_count = r_count;

endmodule

>>> sv/vhs_out_fifo.sv
// two-entry result queue between the core and the output channel
module vhs_out_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  vhs_pkg::t_vhs_result i_data,
    input  logic                 i_ready,
    output logic                 o_valid,
    output vhs_pkg::t_vhs_result o_data,
    output logic                 o_space
);

    vhs_pkg::t_vhs_result r_q0;
    vhs_pkg::t_vhs_result r_q1;
    logic [1:0]           r_cnt;
    logic                 pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q0;
    assign o_space = (r_cnt != 2'd2);
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_push && !pop) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (pop && !i_push) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_push && pop) begin
            if (r_cnt == 2'd1) begin
                r_q0 <= i_data;
            end else begin
                r_q0 <= r_q1;
                r_q1 <= i_data;
            end
        end else if (pop) begin
            r_q0 <= r_q1;
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= i_data;
            end else begin
                r_q1 <= i_data;
            end
        end
    end

endmodule

>>> sv/vad_hangover_smoother.sv
// vad hangover smoother: per-frame voice decision with hangover and lookback
// The slave channel carries one frame per transaction: tdata holds the 16-bit
// silence score, tuser the operation (0 frame, 1 end of stream). The master
// channel returns one result per delayed frame: tdata bit 0 speech_out, bit 1
// smoothed_speech, bit 2 endpoint_hit; tlast is set on every frame result and,
// during a flush, only on the final flushed frame. Registers are written on
// the cfg channel (index 0 threshold, 1 onset, 2 release, 3 endpoint,
// 4 lookback); the user is to write them only while the block is idle, which
// the block itself does not enforce; o_cfg_ready is always high. A frame is
// taken into an input register, processed combinationally from it once the
// output queue has room, and its result enters a two-entry output queue; a
// result is further delayed by lookback_frames frames in the delay line.
// Throughput is one frame per cycle while the output queue has room; a flush
// emits its waiting frames through the single output write per cycle, also
// only while the queue has room. When the receiver stalls the queue fills and
// o_s_axis_tready falls after at most three more frames once the delay line
// is full; nothing is lost. Synchronous reset clears the hangover state, the
// delay line count and the queue, and restores the register defaults; an end
// of stream clears state but keeps the registers.
module vad_hangover_smoother #(
    parameter int MAX_LOOKBACK = vhs_pkg::MaxLookbackDef,
    parameter int COUNT_BITS   = vhs_pkg::CountBitsDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [15:0]                  i_s_axis_tdata,  // silence_score
    input  logic                         i_s_axis_tuser,  // operation
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [7:0]                   o_m_axis_tdata,  // speech_out, smoothed, endpoint, pad
    output logic                         o_m_axis_tlast,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [vhs_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [vhs_pkg::CfgDataW-1:0] i_cfg_data
);

    localparam int CntW = $clog2(MAX_LOOKBACK + 1);

    vhs_pkg::t_vhs_cfg     cfg;
    vhs_pkg::t_vhs_flags   flags;
    vhs_pkg::t_vhs_result  emit;
    vhs_pkg::t_vhs_result  out_data;
    vhs_pkg::t_vhs_op      r_in_op;
    logic [15:0]           r_in_score;
    logic                  r_in_valid;
    logic                  fire;
    logic                  done;
    logic                  clear;
    logic                  emit_valid;
    logic                  space;
    logic [CntW-1:0]       count;

    assign o_cfg_ready     = 1'b1;
    assign fire            = r_in_valid && space;
    assign o_s_axis_tready = !r_in_valid || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_op    <= vhs_pkg::t_vhs_op'(i_s_axis_tuser);
            r_in_score <= i_s_axis_tdata;
        end
    end

    vhs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    vhs_hangover #(
        .COUNT_BITS (COUNT_BITS)
    ) u_hangover (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (fire && (r_in_op == vhs_pkg::OP_FRAME)),
        .i_clear (clear),
        .i_score (r_in_score),
        .i_cfg   (cfg),
        .o_flags (flags)
    );

    vhs_lookback #(
        .MAX_LOOKBACK (MAX_LOOKBACK)
    ) u_lookback (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_op         (r_in_op),
        .i_flags      (flags),
        .i_lookback   (cfg.lookback),
        .o_emit_valid (emit_valid),
        .o_emit       (emit),
        .o_done       (done),
        .o_clear      (clear),
        .o_count      (count)
    );

    vhs_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit_valid),
        .i_data  (emit),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (out_data),
        .o_space (space)
    );

    assign o_m_axis_tdata = {5'd0, out_data.flags};
    assign o_m_axis_tlast = out_data.last;

    // a result is only pushed when the queue has room
    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_valid |-> space)
        else $error("result pushed into full output queue");

    // a finished flush leaves the delay line empty
    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && done && (r_in_op == vhs_pkg::OP_FLUSH)) |=> (count == '0))
        else $error("delay line not empty after flush");

    // with no lookback and nothing waiting a frame comes straight out
    a_direct_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_in_op == vhs_pkg::OP_FRAME) && (cfg.lookback == '0)
         && (count == '0)) |-> (emit_valid && emit.last && (emit.flags == flags)))
        else $error("frame not emitted directly at zero lookback");

endmodule

>>> verif/tb_vad_hangover_smoother.sv
// self-checking testbench of the vad hangover smoother with a decision predictor and scoreboard
module tb_vad_hangover_smoother;

    localparam int HoldCycles   = 200;
    localparam int DrainCycles  = 8;
    localparam int StallLimit   = 1000;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_mode;

    class decision_tracker;
        vhs_pkg::t_vhs_cfg                cfg;
        vhs_pkg::t_vhs_state              state;
        logic [vhs_pkg::CountBitsDef-1:0] voice_run;
        logic [vhs_pkg::CountBitsDef-1:0] silent_run;
        vhs_pkg::t_vhs_flags              history [vhs_pkg::MaxLookbackDef];
        int unsigned                      waiting;
        vhs_pkg::t_vhs_result             decisions_due [$];
        int unsigned                      mismatches;

        function new();
            cfg.score_thr   = vhs_pkg::SCORE_THR_RST;
            cfg.onset       = vhs_pkg::ONSET_RST;
            cfg.release_len = vhs_pkg::RELEASE_RST;
            cfg.endpoint    = vhs_pkg::ENDPOINT_RST;
            cfg.lookback    = vhs_pkg::LOOKBACK_RST;
            mismatches      = 0;
            clear_history();
        endfunction

        function void clear_history();
            state      = vhs_pkg::ST_SILENCE;
            voice_run  = '0;
            silent_run = '0;
            waiting    = 0;
            foreach (history[i]) history[i] = '0;
        endfunction

        function void queue_result(input vhs_pkg::t_vhs_result res);
            decisions_due.insert(decisions_due.size(), res);
        endfunction

        function logic [vhs_pkg::CountBitsDef-1:0] sat_inc(
            input logic [vhs_pkg::CountBitsDef-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function void write_reg(input logic [vhs_pkg::CfgIdxW-1:0] idx,
                                input logic [vhs_pkg::CfgDataW-1:0] data);
            case (idx)
                vhs_pkg::REG_SCORE_THR: cfg.score_thr   = data[vhs_pkg::ScoreW-1:0];
                vhs_pkg::REG_ONSET:     cfg.onset       = data[vhs_pkg::ThrW-1:0];
                vhs_pkg::REG_RELEASE:   cfg.release_len = data[vhs_pkg::ThrW-1:0];
                vhs_pkg::REG_ENDPOINT:  cfg.endpoint    = data[vhs_pkg::ThrW-1:0];
                vhs_pkg::REG_LOOKBACK:  cfg.lookback    = data[vhs_pkg::LookbackW-1:0];
                default: ;
            endcase
        endfunction

        function void take_item(input vhs_pkg::t_vhs_op op,
                                input logic [vhs_pkg::ScoreW-1:0] score);
            vhs_pkg::t_vhs_flags  entry;
            vhs_pkg::t_vhs_result res;
            logic                 voice;
            int unsigned          depth;
            if (op == vhs_pkg::OP_FLUSH) begin
                for (int i = 0; i < waiting; i++) begin
                    res.flags = history[i];
                    res.last  = (i + 1 == waiting);
                    queue_result(res);
                end
                clear_history();
                return;
            end
            voice = (score <= cfg.score_thr);
            entry = '0;
            if (state == vhs_pkg::ST_SILENCE) begin
                if (voice) begin
                    voice_run = sat_inc(voice_run);
                    if (voice_run >= cfg.onset) begin
                        state      = vhs_pkg::ST_SPEECH;
                        silent_run = '0;
                    end
                end else begin
                    voice_run  = '0;
                    silent_run = sat_inc(silent_run);
                    if (silent_run >= cfg.endpoint) entry.endpoint = 1'b1;
                end
            end else begin
                if (!voice) begin
                    silent_run = sat_inc(silent_run);
                    if (silent_run >= cfg.release_len) begin
                        state     = vhs_pkg::ST_SILENCE;
                        voice_run = '0;
                    end
                end else begin
                    silent_run = '0;
                    voice_run  = sat_inc(voice_run);
                end
            end
            entry.speech   = (state == vhs_pkg::ST_SPEECH);
            entry.smoothed = (state == vhs_pkg::ST_SPEECH);
            if (state == vhs_pkg::ST_SPEECH) begin
                for (int i = 0; i < waiting; i++) history[i].speech = 1'b1;
            end
            depth = (cfg.lookback > vhs_pkg::MaxLookbackDef) ? vhs_pkg::MaxLookbackDef
                                                              : cfg.lookback;
            if (waiting < depth) begin
                history[waiting] = entry;
                waiting++;
                return;
            end
            if (waiting == 0) begin
                res.flags = entry;
            end else begin
                res.flags = history[0];
                for (int i = 1; i < waiting; i++) history[i-1] = history[i];
                history[waiting-1] = entry;
            end
            res.last = 1'b1;
            queue_result(res);
        endfunction

        function void compare_field(input string field, input logic [7:0] want,
                                    input logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_decision(input logic [7:0] data, input logic last);
            vhs_pkg::t_vhs_result want;
            if (decisions_due.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual tdata %0h tlast %b",
                         $time, data, last);
                mismatches++;
                return;
            end
            want = decisions_due.pop_front();
            compare_field("speech_out", 8'(want.flags.speech), 8'(data[0]));
            compare_field("smoothed_speech", 8'(want.flags.smoothed), 8'(data[1]));
            compare_field("endpoint_hit", 8'(want.flags.endpoint), 8'(data[2]));
            compare_field("tdata padding", 8'h00, 8'(data[7:3]));
            compare_field("tlast", 8'(want.last), 8'(last));
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_axis_tvalid;
    logic                          o_s_axis_tready;
    logic [15:0]                   i_s_axis_tdata;
    logic                          i_s_axis_tuser;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready;
    logic [7:0]                    o_m_axis_tdata;
    logic                          o_m_axis_tlast;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [vhs_pkg::CfgIdxW-1:0]   i_cfg_index;
    logic [vhs_pkg::CfgDataW-1:0]  i_cfg_data;

    decision_tracker sb;
    bit              hold_req = 1'b0;
    bit              pace_gaps = 1'b1;
    int unsigned     burst_left = 0;
    int unsigned     quiet_cycles = 0;

    vad_hangover_smoother uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_decision(o_m_axis_tdata, o_m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= StallLimit) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, StallLimit);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : rx_pacing
        t_rx_mode    mode;
        int unsigned span;
        int unsigned phase;
        phase = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(8, 48);
            repeat (span) begin
                @(negedge i_clk);
                phase++;
                if (hold_req) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (HoldCycles - 1) @(negedge i_clk);
                    hold_req = 1'b0;
                end else begin
                    case (mode)
                        RX_OPEN:     i_m_axis_tready <= 1'b1;
                        RX_RANDOM:   i_m_axis_tready <= 1'($urandom_range(0, 1));
                        RX_PERIODIC: i_m_axis_tready <= (phase % 4) != 3;
                        default:     i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    task automatic idle_cycles(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
    endtask

    task automatic send_item(input vhs_pkg::t_vhs_op op,
                             input logic [vhs_pkg::ScoreW-1:0] score);
        if (pace_gaps && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            idle_cycles($urandom_range(1, 6));
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= score;
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.take_item(op, score);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (sb.decisions_due.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [vhs_pkg::CfgIdxW-1:0] idx,
                             input logic [vhs_pkg::CfgDataW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [vhs_pkg::ScoreW-1:0] thr,
                             input logic [vhs_pkg::ThrW-1:0] onset,
                             input logic [vhs_pkg::ThrW-1:0] rel,
                             input logic [vhs_pkg::ThrW-1:0] ep,
                             input logic [vhs_pkg::LookbackW-1:0] lb);
        cfg_write(vhs_pkg::REG_SCORE_THR, vhs_pkg::CfgDataW'(thr));
        cfg_write(vhs_pkg::REG_ONSET, vhs_pkg::CfgDataW'(onset));
        cfg_write(vhs_pkg::REG_RELEASE, vhs_pkg::CfgDataW'(rel));
        cfg_write(vhs_pkg::REG_ENDPOINT, vhs_pkg::CfgDataW'(ep));
        cfg_write(vhs_pkg::REG_LOOKBACK, vhs_pkg::CfgDataW'(lb));
    endtask

    function automatic logic [vhs_pkg::ScoreW-1:0] voice_score();
        return vhs_pkg::ScoreW'($urandom_range(0, int'(sb.cfg.score_thr)));
    endfunction

    function automatic logic [vhs_pkg::ScoreW-1:0] silent_score();
        if (sb.cfg.score_thr == '1) return '1;
        return vhs_pkg::ScoreW'($urandom_range(int'(sb.cfg.score_thr) + 1, 65535));
    endfunction

    function automatic logic [vhs_pkg::ThrW-1:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return vhs_pkg::ThrW'($urandom_range(0, 1023));
            1:       return '0;
            default: return vhs_pkg::ThrW'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [vhs_pkg::LookbackW-1:0] pick_lookback();
        case ($urandom_range(0, 7))
            0:       return vhs_pkg::LookbackW'(32);
            1:       return vhs_pkg::LookbackW'($urandom_range(33, 63));
            2:       return '0;
            default: return vhs_pkg::LookbackW'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic run_stream(input int unsigned n, input int unsigned flush_pct);
        int unsigned sent = 0;
        int unsigned pick;
        int unsigned run_len;
        bit          voiced_run;
        while (sent < n) begin
            pick = $urandom_range(0, 99);
            if (pick < flush_pct) begin
                send_item(vhs_pkg::OP_FLUSH, vhs_pkg::ScoreW'($urandom));
                sent++;
            end else if (pick < flush_pct + 10) begin
                send_item(vhs_pkg::OP_FRAME, vhs_pkg::ScoreW'($urandom));
                sent++;
            end else begin
                voiced_run = $urandom_range(0, 1);
                run_len    = $urandom_range(1, 8);
                repeat (run_len) begin
                    send_item(vhs_pkg::OP_FRAME, voiced_run ? voice_score() : silent_score());
                    sent++;
                end
            end
        end
        send_item(vhs_pkg::OP_FLUSH, vhs_pkg::ScoreW'($urandom));
    endtask

    initial begin : stimulus
        sb = new();
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = vhs_pkg::OP_FRAME;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = vhs_pkg::REG_SCORE_THR;
        i_cfg_data      = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: threshold equality, onset, empty flush with a score
        send_item(vhs_pkg::OP_FRAME, 16'd32768);
        send_item(vhs_pkg::OP_FRAME, 16'd0);
        send_item(vhs_pkg::OP_FRAME, 16'd32769);
        repeat (3) send_item(vhs_pkg::OP_FRAME, 16'd0);
        send_item(vhs_pkg::OP_FRAME, 16'hFFFF);
        send_item(vhs_pkg::OP_FLUSH, 16'hFFFF);
        wait_drained();

        // zero thresholds with a short lookback
        configure('0, '0, '0, '0, 6'd4);
        send_item(vhs_pkg::OP_FRAME, 16'd0);
        send_item(vhs_pkg::OP_FRAME, 16'd1);
        send_item(vhs_pkg::OP_FRAME, 16'hFFFF);
        send_item(vhs_pkg::OP_FRAME, 16'hFFFF);
        send_item(vhs_pkg::OP_FRAME, 16'd0);
        send_item(vhs_pkg::OP_FRAME, 16'h8000);
        send_item(vhs_pkg::OP_FLUSH, 16'd0);
        wait_drained();

        configure('1, '1, '1, '1, 6'd1);
        send_item(vhs_pkg::OP_FRAME, 16'hFFFF);
        send_item(vhs_pkg::OP_FRAME, 16'h5A5A);
        send_item(vhs_pkg::OP_FLUSH, 16'hA5A5);
        wait_drained();

        // lookback lowered while frames still wait
        configure(16'd32768, 10'd2, 10'd2, 10'd2, 6'd8);
        repeat (5) send_item(vhs_pkg::OP_FRAME, 16'd100);
        wait_drained();
        cfg_write(vhs_pkg::REG_LOOKBACK, vhs_pkg::CfgDataW'(2));
        send_item(vhs_pkg::OP_FRAME, 16'hF000);
        send_item(vhs_pkg::OP_FRAME, 16'hF000);
        send_item(vhs_pkg::OP_FRAME, 16'd0);
        send_item(vhs_pkg::OP_FLUSH, 16'd0);
        wait_drained();

        // receiver holds off while frames keep coming
        pace_gaps = 1'b0;
        configure(vhs_pkg::ScoreW'($urandom), 10'd1, 10'd2, 10'd3, '0);
        hold_req = 1'b1;
        run_stream(24, 0);
        wait_drained();
        pace_gaps = 1'b1;

        // lookback beyond the delay line depth, full delay line on flush
        configure(vhs_pkg::ScoreW'($urandom), 10'd2, 10'd3, 10'd4, 6'd63);
        run_stream(36, 0);
        wait_drained();

        repeat (3) begin
            configure(vhs_pkg::ScoreW'($urandom), pick_count(), pick_count(), pick_count(),
                      pick_lookback());
            run_stream(10, 8);
            wait_drained();
        end

        if (sb.mismatches == 0 && sb.decisions_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (sb.decisions_due.size() != 0)
                $display("%0t: %0d expected results never arrived", $time,
                         sb.decisions_due.size());
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
